### rtl/bbsf_pkg.sv
// Shared types and constants for the bounded byte stream FIFO.
// No dependencies; the interfaces and the top level use this package.
`timescale 1ns / 1ps
`default_nettype none

package bbsf_pkg;

    localparam int CFG_W   = 13;
    localparam int CNT13_W = 13;
    localparam int TOTAL_W = 64;

    localparam logic [CFG_W-1:0] CAPACITY_RESET = 13'd4096;

    // Operation codes
    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_PEEK  = 3'd2;
    localparam logic [2:0] OP_POP   = 3'd3;
    localparam logic [2:0] OP_END   = 3'd4;

    typedef struct packed {
        logic [2:0]         operation;
        logic [7:0]         write_byte;
        logic [CNT13_W-1:0] amount;
    } t_in_item;

    typedef struct packed {
        logic               done_res;
        logic [7:0]         read_byte;
        logic [CNT13_W-1:0] popped;
        logic [CNT13_W-1:0] buffered;
        logic [CNT13_W-1:0] free_space;
        logic               closed;
        logic               at_end;
        logic [TOTAL_W-1:0] total_written;
        logic [TOTAL_W-1:0] total_read;
    } t_out_item;

endpackage

`default_nettype wire

### rtl/bbsf_if.sv
// Valid/ready channel interfaces for operation items and result items.
// Depends on bbsf_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface bbsf_in_if;
    logic              valid;
    logic              ready;
    bbsf_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bbsf_out_if;
    logic               valid;
    logic               ready;
    bbsf_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/bounded_byte_stream_fifo.sv
// Bounded byte stream FIFO: ring buffer in one memory plus status counters.
// Depends on bbsf_pkg and the channel interfaces in bbsf_if.sv.
`timescale 1ns / 1ps
`default_nettype none

// Takes one operation per cycle; its result appears in the output register in
// the cycle after the transfer and the next operation is taken in that same
// cycle unless the result side stalls. The rate is set by the byte store: a single
// memory with one write port and one registered read port, each used at most
// once per operation. The store needs no clearing pass after reset, since only
// bytes that were written are ever read back. Capacity may be written only
// while no operation is in flight; values above DEPTH behave as DEPTH.
module bounded_byte_stream_fifo #(
    parameter int DEPTH = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bbsf_pkg::CFG_W-1:0] i_cfg_wdata,
    bbsf_in_if.sink                    i_in_ch,
    bbsf_out_if.source                 o_out_ch
);

    import bbsf_pkg::*;

    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WIDE_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [AW:0]       DEPTH_A = (AW + 1)'(DEPTH);
    localparam logic [WIDE_W-1:0] DEPTH_W = WIDE_W'(DEPTH);

    logic [7:0] mem [DEPTH];

    logic [CFG_W-1:0]   r_capacity;
    logic [AW-1:0]      r_head;
    logic [CNT_W-1:0]   r_held;
    logic               r_ended;
    logic [TOTAL_W-1:0] r_wr_count;
    logic [TOTAL_W-1:0] r_rd_count;
    logic               r_out_valid;
    t_out_item          r_res;
    logic               r_byte_valid;
    logic [7:0]         r_rd_data;

    t_out_item          n_res;
    logic               n_byte_valid;
    logic [AW-1:0]      n_head;
    logic [CNT_W-1:0]   n_held;
    logic               n_ended;
    logic [TOTAL_W-1:0] n_wr_count;
    logic [TOTAL_W-1:0] n_rd_count;

    logic               accept;
    logic               wr_ok;
    logic [CNT_W-1:0]   take;
    logic [WIDE_W-1:0]  cap_w;
    logic [WIDE_W-1:0]  eff_cap;
    logic [WIDE_W-1:0]  held_w;
    logic [WIDE_W-1:0]  amt_w;
    logic [WIDE_W-1:0]  n_held_w;
    logic [WIDE_W-1:0]  free_w;
    logic [WIDE_W-1:0]  take_w;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic [AW:0]        rd_off;
    t_out_item          out_item;

    // Wrap head plus offset back into the ring; offset never exceeds DEPTH.
    function automatic logic [AW-1:0] f_ring(input logic [AW-1:0] base,
                                             input logic [AW:0]   offset);
        logic [AW:0] sum;
        sum = {1'b0, base} + offset;
        if (sum >= DEPTH_A) begin
            sum = sum - DEPTH_A;
        end
        return sum[AW-1:0];
    endfunction

    assign accept        = i_in_ch.valid && i_in_ch.ready;
    assign i_in_ch.ready = !r_out_valid || o_out_ch.ready;

    assign cap_w   = WIDE_W'(r_capacity);
    assign eff_cap = (cap_w > DEPTH_W) ? DEPTH_W : cap_w;
    assign held_w  = WIDE_W'(r_held);
    assign amt_w   = WIDE_W'(i_in_ch.payload.amount);

    always_comb begin
        wr_ok        = 1'b0;
        take         = '0;
        n_byte_valid = 1'b0;
        n_ended      = r_ended;
        rd_off       = '0;
        case (i_in_ch.payload.operation)
            OP_WRITE: begin
                wr_ok = held_w < eff_cap;
            end
            OP_READ: begin
                if (r_held != '0) begin
                    take         = CNT_W'(1);
                    n_byte_valid = 1'b1;
                end
            end
            OP_PEEK: begin
                if (amt_w < held_w) begin
                    n_byte_valid = 1'b1;
                    rd_off       = amt_w[AW:0];
                end
            end
            OP_POP: begin
                take = (amt_w < held_w) ? amt_w[CNT_W-1:0] : r_held;
            end
            OP_END: begin
                n_ended = 1'b1;
            end
            default: begin
                // undefined codes leave the state untouched
            end
        endcase
    end

    assign wr_addr = f_ring(r_head, (AW + 1)'(r_held));
    assign rd_addr = f_ring(r_head, rd_off);
    assign n_head  = f_ring(r_head, (AW + 1)'(take));

    assign n_held     = r_held + CNT_W'(wr_ok) - take;
    assign n_wr_count = r_wr_count + TOTAL_W'(wr_ok);
    assign n_rd_count = r_rd_count + TOTAL_W'(take);
    assign n_held_w   = WIDE_W'(n_held);
    assign take_w     = WIDE_W'(take);
    assign free_w     = (n_held_w < eff_cap) ? (eff_cap - n_held_w) : '0;

    always_comb begin
        n_res               = '0;
        n_res.done_res      = wr_ok || n_byte_valid;
        n_res.read_byte     = '0;
        n_res.popped        = take_w[CNT13_W-1:0];
        n_res.buffered      = n_held_w[CNT13_W-1:0];
        n_res.free_space    = free_w[CNT13_W-1:0];
        n_res.closed        = n_ended;
        n_res.at_end        = n_ended && (n_held == '0);
        n_res.total_written = n_wr_count;
        n_res.total_read    = n_rd_count;
    end

    // Byte store: write a transferred byte, read the head or peek slot.
    always_ff @(posedge i_clk) begin
        if (accept && wr_ok) begin
            mem[wr_addr] <= i_in_ch.payload.write_byte;
        end
        if (accept) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAPACITY_RESET;
            r_head      <= '0;
            r_held      <= '0;
            r_ended     <= 1'b0;
            r_wr_count  <= '0;
            r_rd_count  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (accept) begin
                r_head      <= n_head;
                r_held      <= n_held;
                r_ended     <= n_ended;
                r_wr_count  <= n_wr_count;
                r_rd_count  <= n_rd_count;
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; hold while the output side stalls.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res        <= n_res;
            r_byte_valid <= n_byte_valid;
        end
    end

    always_comb begin
        out_item           = r_res;
        out_item.read_byte = r_byte_valid ? r_rd_data : 8'd0;
    end

    assign o_out_ch.valid   = r_out_valid;
    assign o_out_ch.payload = out_item;

endmodule

`default_nettype wire
